>>> rtl/hpe_pkg.sv
// Package for the Horner polynomial evaluator: widths, opcodes and the
// control struct passed from the sequencer to the multiply-add unit.
// No dependencies.
`default_nettype none

package hpe_pkg;

    localparam int MAX_DEGREE = 10;
    localparam int DEPTH      = MAX_DEGREE + 1;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int Q_W        = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 2 * Q_W;
    localparam int CIDX_W     = 4;
    localparam int DEG_W      = 4;

    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic load_x;
        logic add_en;
        logic mul_en;
        logic first;
    } mac_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/hpe_coef_store.sv
// Coefficient store: one write port, one registered read port.
// Depends on hpe_pkg.
`default_nettype none

module hpe_coef_store (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [hpe_pkg::IDX_W-1:0]    waddr,
    input  wire logic [hpe_pkg::Q_W-1:0]      wdata,
    input  wire logic                         re,
    input  wire logic [hpe_pkg::IDX_W-1:0]    raddr,
    output logic      [hpe_pkg::Q_W-1:0]      rdata
);

    logic [hpe_pkg::Q_W-1:0] mem [hpe_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/hpe_mac.sv
// Shared multiply-add unit: a registered 32x32 multiply, and an add stage
// that rescales the product, adds a coefficient and saturates.
// Depends on hpe_pkg.
`default_nettype none

module hpe_mac (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hpe_pkg::mac_ctrl_t           ctrl,
    input  wire logic [hpe_pkg::Q_W-1:0]      x_in,
    input  wire logic [hpe_pkg::Q_W-1:0]      coef,
    output logic      [hpe_pkg::Q_W-1:0]      acc,
    output logic                              ovf
);

    logic signed [hpe_pkg::Q_W-1:0]    x_reg;
    logic signed [hpe_pkg::Q_W-1:0]    acc_reg,  acc_next;
    logic signed [hpe_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                              ovf_reg,  ovf_next;

    logic [hpe_pkg::Q_W-1:0] scaled;
    logic                    scaled_ovf;
    logic [hpe_pkg::Q_W:0]   sum;
    logic [hpe_pkg::Q_W-1:0] sum_sat;
    logic                    sum_ovf;

    // The product fits after the shift only if its top bits are all copies
    // of the sign of the kept part.
    always_comb
    begin
        scaled     = '0;
        scaled_ovf = 1'b0;
        if (!ctrl.first)
        begin
            if ((&prod_reg[hpe_pkg::PROD_W-1:hpe_pkg::FRAC_W+hpe_pkg::Q_W-1]) ||
                (~|prod_reg[hpe_pkg::PROD_W-1:hpe_pkg::FRAC_W+hpe_pkg::Q_W-1]))
            begin
                scaled = prod_reg[hpe_pkg::FRAC_W+hpe_pkg::Q_W-1:hpe_pkg::FRAC_W];
            end
            else
            begin
                scaled     = prod_reg[hpe_pkg::PROD_W-1] ? hpe_pkg::Q_MIN : hpe_pkg::Q_MAX;
                scaled_ovf = 1'b1;
            end
        end
    end

    always_comb
    begin
        sum     = {scaled[hpe_pkg::Q_W-1], scaled} + {coef[hpe_pkg::Q_W-1], coef};
        sum_ovf = sum[hpe_pkg::Q_W] != sum[hpe_pkg::Q_W-1];
        if (sum_ovf)
        begin
            sum_sat = sum[hpe_pkg::Q_W] ? hpe_pkg::Q_MIN : hpe_pkg::Q_MAX;
        end
        else
        begin
            sum_sat = sum[hpe_pkg::Q_W-1:0];
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        prod_next = prod_reg;
        ovf_next  = ovf_reg;
        if (ctrl.load_x)
        begin
            ovf_next = 1'b0;
        end
        if (ctrl.add_en)
        begin
            acc_next = sum_sat;
            ovf_next = ovf_reg | scaled_ovf | sum_ovf;
        end
        if (ctrl.mul_en)
        begin
            prod_next = acc_reg * x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg <= 1'b0;
        end
        else
        begin
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        if (ctrl.load_x)
        begin
            x_reg <= x_in;
        end
    end

    assign acc = acc_reg;
    assign ovf = ovf_reg;

endmodule

`default_nettype wire

>>> rtl/horner_polynomial_evaluator_top.sv
// Horner polynomial evaluator, top level: stream ports, sequencer, output register.
// Depends on hpe_pkg, hpe_coef_store and hpe_mac.
//
// A load transfer (tuser 0) writes one signed Q16.16 coefficient; an index above
// the maximum degree is dropped. An evaluate transfer (tuser 1) carries x and
// yields one result of the polynomial of degree d, where d is the degree register
// clamped to the maximum degree. The sequencer works through the one shared
// multiplier: the top coefficient d is taken by an add step, and each lower
// coefficient needs a multiply step followed by a rescale, add and saturate step;
// then the result moves to the output register. The input is not ready while an
// evaluation runs or while a finished result waits for the output register.
// Results saturate to the 32-bit range and tuser flags any clamp. Every
// coefficient up to the degree in use must be loaded before evaluating.
`default_nettype none

module horner_polynomial_evaluator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,      // degree_in_use
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // coef_index[3:0], value[35:4], zero pad
    input  wire logic        s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // poly_value[31:0]
    output logic             m_axis_tuser    // overflow
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ADD  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [hpe_pkg::DEG_W-1:0] degree_reg;
    logic [hpe_pkg::IDX_W-1:0] k_reg, k_next;
    logic                      first_reg, first_next;
    logic                      out_valid_reg, out_valid_next;
    logic [hpe_pkg::Q_W-1:0]   out_data_reg, out_data_next;
    logic                      out_ovf_reg, out_ovf_next;

    logic [hpe_pkg::CIDX_W-1:0] in_index;
    logic [hpe_pkg::Q_W-1:0]    in_value;
    logic                       in_xfer;
    logic [hpe_pkg::IDX_W-1:0]  deg_eff;

    hpe_pkg::mac_ctrl_t        ctrl;
    logic                      st_we, st_re;
    logic [hpe_pkg::IDX_W-1:0] st_raddr;
    logic [hpe_pkg::Q_W-1:0]   st_rdata;
    logic [hpe_pkg::Q_W-1:0]   mac_acc;
    logic                      mac_ovf;

    assign in_index = s_axis_tdata[hpe_pkg::CIDX_W-1:0];
    assign in_value = s_axis_tdata[hpe_pkg::CIDX_W+hpe_pkg::Q_W-1:hpe_pkg::CIDX_W];
    assign in_xfer  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        if (int'(degree_reg) > hpe_pkg::MAX_DEGREE)
        begin
            deg_eff = hpe_pkg::IDX_W'(hpe_pkg::MAX_DEGREE);
        end
        else
        begin
            deg_eff = hpe_pkg::IDX_W'(degree_reg);
        end
    end

    assign st_we = in_xfer && (s_axis_tuser == hpe_pkg::OP_LOAD) &&
                   (int'(in_index) <= hpe_pkg::MAX_DEGREE);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_ovf_next   = out_ovf_reg;
        ctrl           = '0;
        ctrl.first     = first_reg;
        st_re          = 1'b0;
        st_raddr       = k_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (s_axis_tuser == hpe_pkg::OP_EVAL))
                begin
                    ctrl.load_x = 1'b1;
                    st_re       = 1'b1;
                    st_raddr    = deg_eff;
                    k_next      = deg_eff;
                    first_next  = 1'b1;
                    state_next  = ST_ADD;
                end
            end
            ST_ADD:
            begin
                ctrl.add_en = 1'b1;
                if (k_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // Fetch the next coefficient while the product is formed.
                ctrl.mul_en = 1'b1;
                st_re       = 1'b1;
                st_raddr    = k_reg - hpe_pkg::IDX_W'(1);
                k_next      = k_reg - hpe_pkg::IDX_W'(1);
                first_next  = 1'b0;
                state_next  = ST_ADD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = mac_acc;
                    out_ovf_next   = mac_ovf;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            degree_reg    <= hpe_pkg::DEG_W'(hpe_pkg::MAX_DEGREE);
            k_reg         <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                degree_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_ovf_reg  <= out_ovf_next;
    end

    hpe_coef_store u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (hpe_pkg::IDX_W'(in_index)),
        .wdata (in_value),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    hpe_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .x_in  (in_value),
        .coef  (st_rdata),
        .acc   (mac_acc),
        .ovf   (mac_ovf)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_ovf_reg;

`ifndef SYNTHESIS
    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == hpe_pkg::OP_EVAL))
        |=> (state_reg == ST_ADD))
    else $error("evaluate transfer did not start the sequencer");

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (int'(k_reg) <= hpe_pkg::MAX_DEGREE))
    else $error("coefficient counter beyond maximum degree");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (!m_axis_tvalid || m_axis_tready))
        |=> (m_axis_tvalid && (state_reg == ST_IDLE)))
    else $error("finished evaluation not moved to the output register");
`endif

endmodule

`default_nettype wire
